// ===== rtl/bwgw_pkg.sv =====
`default_nettype none
package bwgw_pkg;

   // default grid geometry and pass count
   localparam int GRID_WIDTH_DEF  = 4;
   localparam int GRID_HEIGHT_DEF = 8;
   localparam int DIR_BITS_DEF    = 8;

   // fixed field widths
   localparam int WORD_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [BYTE_W-1:0] LEVEL_MAX = 8'hFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_MODE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_ENABLE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTENSITY    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN       = 3'd5;

   // step directions
   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_EAST  = 2'd1;
   localparam logic [1:0] DIR_SOUTH = 2'd2;
   localparam logic [1:0] DIR_WEST  = 2'd3;

   // sequencer to walker control
   typedef struct packed {
      logic       load;
      logic       step;
      logic [1:0] dir;
   } walk_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/bit_word_grid_walk_core.sv =====
// Channel  Direction  Ports                                          Handshake
// req      in         req_word                                       req_valid / req_stall
// rsp      out        rsp_cell_index, rsp_cell_level, rsp_last       rsp_valid / rsp_stall
// csr      in         csr_index, csr_wdata                           csr_we (write only)
//
// One item first walks S steps over L step slots, S = steps taken, L = step slots
// (4 in count mode, 4 * DIR_BITS in bit mode); in count mode S is at most 1020.
// Then one result is shown per cell, 32 cells in the default grid.
// The pace is set by the single step unit and the read-modify-write of the mark memory.
// Reset is synchronous; it restores the register defaults and drops all marks.
// req_stall is high for the whole item; rsp_stall holds the current result in place.
`default_nettype none
module bit_word_grid_walk_core import bwgw_pkg::*; #(
   parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
   parameter int DIR_BITS    = DIR_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [WORD_W-1:0]     req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [INDEX_W-1:0]    rsp_cell_index,
   output logic      [BYTE_W-1:0]     rsp_cell_level,
   output logic                       rsp_last,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int CW = $clog2(CELLS);
   localparam int PW = $clog2(DIR_BITS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WALK  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_RD    = 3'd3;
   localparam logic [2:0] ST_LD    = 3'd4;
   localparam logic [2:0] ST_SHOW  = 3'd5;

   // configuration
   logic                 count_mode_ff, gate_mode_ff, clamp_ff;
   logic [BYTE_W-1:0]    intensity_ff;
   logic [5:0]           rotate_ff;
   logic [INDEX_W-1:0]   origin_ff;

   // sequencer
   logic [2:0]           state_ff, state_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic [1:0]           dir_ff, dir_in;
   logic [PW-1:0]        pass_ff, pass_in;
   logic [BYTE_W-1:0]    rem_ff, rem_in;
   logic                 pend_ff;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 req_take, rsp_take, stepping, slot_last, idx_last;
   logic [2*WORD_W-1:0]  rot_wide;
   logic [1:0]           next_dir;
   logic [PW-1:0]        next_pass;

   // result registers
   logic                 rsp_valid_ff;
   logic [INDEX_W-1:0]   rsp_index_ff;
   logic [BYTE_W-1:0]    rsp_level_ff;
   logic                 rsp_last_ff;
   logic [CW+INDEX_W-1:0] idx_wide;
   logic [2*BYTE_W-1:0]  product;
   logic [BYTE_W-1:0]    level;

   walk_ctl_type         walk_ctl;
   logic [CW-1:0]        cell_addr, read_addr;
   logic [BYTE_W-1:0]    read_mark;
   logic                 mem_busy;

   // steps for one direction slot: a count, or one bit of the pass
   function automatic logic [BYTE_W-1:0] slot_count(
      input logic [WORD_W-1:0] w,
      input logic [1:0]        d,
      input logic [PW-1:0]     p,
      input logic              cmode
   );
      logic [BYTE_W-1:0] b;
      logic [BYTE_W:0]   sh;
      begin
         case (d)
            DIR_NORTH: b = w[31:24];
            DIR_EAST:  b = w[23:16];
            DIR_SOUTH: b = w[15:8];
            default:   b = w[7:0];
         endcase
         sh = {1'b0, b} >> p;
         slot_count = cmode ? b : BYTE_W'(sh[0]);
      end
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         count_mode_ff <= 1'b1;
         gate_mode_ff  <= 1'b1;
         clamp_ff      <= 1'b0;
         intensity_ff  <= 8'd1;
         rotate_ff     <= '0;
         origin_ff     <= 5'd18;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COUNT_MODE:   count_mode_ff <= csr_wdata[0];
            CSR_GATE_MODE:    gate_mode_ff  <= csr_wdata[0];
            CSR_CLAMP_ENABLE: clamp_ff      <= csr_wdata[0];
            CSR_INTENSITY:    intensity_ff  <= csr_wdata;
            CSR_ROTATE:       rotate_ff     <= csr_wdata[5:0];
            CSR_ORIGIN:       origin_ff     <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   assign req_take = req_valid && (state_ff == ST_IDLE);
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign stepping = (state_ff == ST_WALK) && (rem_ff != '0);
   assign slot_last = (dir_ff == DIR_WEST) && (count_mode_ff || pass_ff == PW'(DIR_BITS));
   assign idx_last = (idx_ff == CW'(CELLS - 1));

   // rotate left by the amount modulo 32
   assign rot_wide = {req_word, req_word} << rotate_ff[4:0];

   // next direction slot
   always_comb begin
      next_dir  = dir_ff + 1'b1;
      next_pass = pass_ff;
      if (dir_ff == DIR_WEST) begin
         next_pass = pass_ff + 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      word_in  = word_ff;
      dir_in   = dir_ff;
      pass_in  = pass_ff;
      rem_in   = rem_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               word_in  = rot_wide[2*WORD_W-1:WORD_W];
               dir_in   = DIR_NORTH;
               pass_in  = PW'(1);
               rem_in   = slot_count(rot_wide[2*WORD_W-1:WORD_W], DIR_NORTH, PW'(1),
                                     count_mode_ff);
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (rem_ff != '0) begin
               rem_in = rem_ff - 1'b1;
            end else if (slot_last) begin
               state_in = ST_DRAIN;
            end else begin
               dir_in  = next_dir;
               pass_in = next_pass;
               rem_in  = slot_count(word_ff, next_dir, next_pass, count_mode_ff);
            end
         end
         ST_DRAIN: begin
            if (!pend_ff && !mem_busy) begin
               idx_in   = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: state_in = ST_LD;
         ST_LD: state_in = ST_SHOW;
         ST_SHOW: begin
            if (rsp_take) begin
               if (idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_LD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= stepping;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      dir_ff  <= dir_in;
      pass_ff <= pass_in;
      rem_ff  <= rem_in;
      idx_ff  <= idx_in;
   end

   // walker and mark memory
   assign walk_ctl.load = req_take;
   assign walk_ctl.step = stepping;
   assign walk_ctl.dir  = dir_ff;

   bwgw_walk #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .ctl       (walk_ctl),
      .origin    (origin_ff),
      .cell_addr (cell_addr)
   );

   // read ahead the next cell while a result waits
   assign read_addr = (state_ff == ST_SHOW && !idx_last) ? idx_ff + 1'b1 : idx_ff;

   bwgw_mark_mem #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_mark_mem (
      .clock     (clock),
      .reset     (reset),
      .clear     (req_take),
      .gate_mode (gate_mode_ff),
      .mark_en   (pend_ff),
      .mark_addr (cell_addr),
      .read_addr (read_addr),
      .read_mark (read_mark),
      .busy      (mem_busy)
   );

   // scale the mark into a level, or in gate mode map any set mark to the full level
   assign product = read_mark * intensity_ff;
   always_comb begin
      if (gate_mode_ff) begin
         level = (read_mark != '0) ? LEVEL_MAX : '0;
      end else if (clamp_ff && product[2*BYTE_W-1:BYTE_W] != '0) begin
         level = LEVEL_MAX;
      end else begin
         level = product[BYTE_W-1:0];
      end
   end

   assign idx_wide = {{INDEX_W{1'b0}}, idx_ff};

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_LD) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LD) begin
         rsp_index_ff <= idx_wide[INDEX_W-1:0];
         rsp_level_ff <= level;
         rsp_last_ff  <= idx_last;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_index = rsp_index_ff;
   assign rsp_cell_level = rsp_level_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   a_rsp_only_in_show: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_SHOW))
      else $error("result shown outside the show state");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_last_ff) |=> (state_ff == ST_IDLE))
      else $error("item not finished after last result");

   a_take_starts_walk: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_WALK))
      else $error("accepted item did not start a walk");

   a_no_mark_in_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD || state_ff == ST_LD || state_ff == ST_SHOW)
      |-> (!pend_ff && !mem_busy))
      else $error("mark update still in flight during output");
`endif

endmodule
`default_nettype wire

// ===== rtl/bwgw_walk.sv =====
`default_nettype none
module bwgw_walk import bwgw_pkg::*; #(
   parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
   localparam int XW = $clog2(GRID_WIDTH),
   localparam int YW = $clog2(GRID_HEIGHT),
   localparam int CW = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire walk_ctl_type       ctl,
   input  wire logic [INDEX_W-1:0] origin,
   output logic      [CW-1:0]      cell_addr
);

   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int OW = (CW > INDEX_W ? CW : INDEX_W) + 1;

   logic [XW-1:0] x_ff, x_in, org_x;
   logic [YW-1:0] y_ff, y_in, org_y;
   logic [OW-1:0] org_wide, org_clip;

   // saturate the origin at the last cell, then split into x and y
   always_comb begin
      org_wide = OW'(origin);
      org_clip = (org_wide < OW'(CELLS)) ? org_wide : OW'(CELLS - 1);
      org_y = '0;
      for (int k = 1; k < GRID_HEIGHT; k++) begin
         if (org_clip >= OW'(k * GRID_WIDTH)) begin
            org_y = YW'(k);
         end
      end
      org_x = XW'(org_clip - OW'(org_y) * OW'(GRID_WIDTH));
   end

   // load the origin, or advance one cell on the torus
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (ctl.load) begin
         x_in = org_x;
         y_in = org_y;
      end else if (ctl.step) begin
         case (ctl.dir)
            DIR_NORTH: y_in = (y_ff == '0) ? YW'(GRID_HEIGHT - 1) : y_ff - 1'b1;
            DIR_EAST:  x_in = (x_ff == XW'(GRID_WIDTH - 1)) ? '0 : x_ff + 1'b1;
            DIR_SOUTH: y_in = (y_ff == YW'(GRID_HEIGHT - 1)) ? '0 : y_ff + 1'b1;
            default:   x_in = (x_ff == '0) ? XW'(GRID_WIDTH - 1) : x_ff - 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign cell_addr = CW'(x_ff) + CW'(CW'(y_ff) * CW'(GRID_WIDTH));

endmodule
`default_nettype wire

// ===== rtl/bwgw_mark_mem.sv =====
`default_nettype none
module bwgw_mark_mem import bwgw_pkg::*; #(
   parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
   localparam int CW = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire logic              gate_mode,
   input  wire logic              mark_en,
   input  wire logic [CW-1:0]     mark_addr,
   input  wire logic [CW-1:0]     read_addr,
   output logic      [BYTE_W-1:0] read_mark,
   output logic                   busy
);

   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;

   logic [BYTE_W-1:0] mem [CELLS];
   logic [CELLS-1:0]  valid_ff;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              rd_valid_ff;
   logic              wr_pend_ff;
   logic [CW-1:0]     wr_addr_ff;
   logic [CW-1:0]     addr;
   logic [BYTE_W-1:0] old_mark, new_mark;

   // a pending mark owns the read port
   assign addr = mark_en ? mark_addr : read_addr;

   assign old_mark = rd_valid_ff ? rd_data_ff : '0;
   assign new_mark = gate_mode ? (old_mark ^ BYTE_W'(1)) : old_mark + 1'b1;

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff  <= mem[addr];
      rd_valid_ff <= valid_ff[addr];
      wr_addr_ff  <= addr;
   end

   // write back the updated mark in the cycle after its read
   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         mem[wr_addr_ff] <= new_mark;
      end
   end

   // valid bits: drop all at a new item, set on each write
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= mark_en;
         if (clear) begin
            valid_ff <= '0;
         end else if (wr_pend_ff) begin
            valid_ff[wr_addr_ff] <= 1'b1;
         end
      end
   end

   assign read_mark = old_mark;
   assign busy      = wr_pend_ff;

endmodule
`default_nettype wire
